/* src/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is checked during reset too.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/kwq_pkg.sv */
// Shared types, codes and default sizes of the keyed wait queue table.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package kwq_pkg;

    localparam int NUM_KEYS_DEF    = 16;
    localparam int NUM_WAITERS_DEF = 256;
    localparam int KEY_BITS_DEF    = 32;

    localparam int KEY_IN_W = 32;
    localparam int ID_W     = 8;
    localparam int ID_SPAN  = 2 ** ID_W;
    localparam int LEN_W    = 9;
    localparam int ST_W     = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_POP = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_ADDED     = 2'd0,
        ST_POPPED    = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } kwq_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic scan;
        logic new_ent;
        logic app_clr;
        logic app_wr;
        logic pop_rd;
        logic pop_wr;
        logic finish;
    } kwq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic is_pop;
        logic found;
        logic free_found;
        logic len_full;
        logic out_free;
    } kwq_sts_t;

endpackage

`default_nettype wire

/* src/kwq_ctrl.sv */
// Sequencer of the keyed wait queue table: scan, decide, update, respond.
// Depends on kwq_pkg for the command and status structs.
`default_nettype none

module kwq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire kwq_pkg::kwq_sts_t sts,
    output kwq_pkg::kwq_cmd_t    cmd
);
    import kwq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_EXEC    = 9'b000000100,
        S_NEW     = 9'b000001000,
        S_APP_CLR = 9'b000010000,
        S_APP_WR  = 9'b000100000,
        S_POP_RD  = 9'b001000000,
        S_POP_WR  = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (sts.is_pop) begin
                    state_next = sts.found ? S_POP_RD : S_DONE;
                end else if (sts.found) begin
                    state_next = sts.len_full ? S_DONE : S_APP_CLR;
                end else begin
                    state_next = sts.free_found ? S_NEW : S_DONE;
                end
            end
            S_NEW: begin
                cmd.new_ent = 1'b1;
                state_next  = S_DONE;
            end
            S_APP_CLR: begin
                cmd.app_clr = 1'b1;
                state_next  = S_APP_WR;
            end
            S_APP_WR: begin
                cmd.app_wr = 1'b1;
                state_next = S_DONE;
            end
            S_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_WR;
            end
            S_POP_WR: begin
                cmd.pop_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/kwq_datapath.sv */
// Datapath of the keyed wait queue table: request registers, key entry
// memory with valid bits, link memory and the result register.
// Depends on kwq_pkg for sizes, codes and the command and status structs.
`default_nettype none

module kwq_datapath #(
    parameter int NUM_KEYS    = kwq_pkg::NUM_KEYS_DEF,
    parameter int NUM_WAITERS = kwq_pkg::NUM_WAITERS_DEF,
    parameter int KEY_BITS    = kwq_pkg::KEY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire kwq_pkg::kwq_cmd_t             cmd,
    output kwq_pkg::kwq_sts_t                  sts,
    input  wire logic                          s_mode,
    input  wire logic [kwq_pkg::KEY_IN_W-1:0]  s_key,
    input  wire logic [kwq_pkg::ID_W-1:0]      s_waiter_id,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kwq_pkg::ST_W-1:0]           m_status,
    output logic [kwq_pkg::ID_W-1:0]           m_popped_id
);
    import kwq_pkg::*;

    localparam int KEY_W = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int KI    = $clog2(NUM_KEYS);
    localparam int LA    = $clog2(NUM_WAITERS);
    localparam logic [KI-1:0] LAST_IDX = KI'(NUM_KEYS - 1);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  head;
        logic [ID_W-1:0]  tail;
        logic [LEN_W-1:0] len;
    } ent_t;

    // Link address of every possible id.
    logic [LA-1:0] la_tab [ID_SPAN];
    for (genvar g = 0; g < ID_SPAN; g++) begin : g_la
        assign la_tab[g] = LA'(g % NUM_WAITERS);
    end

    ent_t              ent_mem  [NUM_KEYS];
    logic [ID_W-1:0]   link_mem [NUM_WAITERS];

    logic              req_mode_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [ID_W-1:0]   req_id_reg;

    logic [KI-1:0]     scan_addr_reg;
    logic [KI-1:0]     cmp_idx_reg;
    logic              cmp_vld_reg;
    ent_t              ent_rd_reg;

    logic              found_reg;
    logic              free_found_reg;
    logic [KI-1:0]     found_idx_reg;
    logic [KI-1:0]     free_idx_reg;
    logic [ID_W-1:0]   ent_head_reg;
    logic [ID_W-1:0]   ent_tail_reg;
    logic [LEN_W-1:0]  ent_len_reg;
    logic [ID_W-1:0]   link_rd_reg;

    logic [NUM_KEYS-1:0] valid_reg;

    logic              m_valid_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic [ID_W-1:0]   m_popped_reg;

    logic              rd_hit;
    logic              rd_free;
    logic              ent_we;
    logic [KI-1:0]     ent_waddr;
    ent_t              ent_wdata;
    logic              link_we;
    logic [LA-1:0]     link_waddr;
    logic [ID_W-1:0]   link_wdata;
    kwq_status_t       res_status;
    logic [ID_W-1:0]   res_popped;

    // Compare stage of the scan, one entry per cycle.
    assign rd_hit  = cmp_vld_reg && valid_reg[cmp_idx_reg] &&
                     (ent_rd_reg.key == req_key_reg);
    assign rd_free = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    assign sts.scan_done  = cmp_vld_reg && (rd_hit || (cmp_idx_reg == LAST_IDX));
    assign sts.is_pop     = (req_mode_reg == MODE_POP);
    assign sts.found      = found_reg;
    assign sts.free_found = free_found_reg;
    assign sts.len_full   = (ent_len_reg == LEN_MAX);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_mode_reg <= s_mode;
            req_key_reg  <= s_key[KEY_W-1:0];
            req_id_reg   <= s_waiter_id;
        end
        if (cmd.scan) begin
            cmp_idx_reg <= scan_addr_reg;
        end
        if (cmd.scan && rd_hit && !found_reg) begin
            found_idx_reg <= cmp_idx_reg;
            ent_head_reg  <= ent_rd_reg.head;
            ent_tail_reg  <= ent_rd_reg.tail;
            ent_len_reg   <= ent_rd_reg.len;
        end
        if (cmd.scan && rd_free && !free_found_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish) begin
            m_status_reg <= res_status;
            m_popped_reg <= res_popped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.start) begin
                scan_addr_reg  <= '0;
                cmp_vld_reg    <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmd.scan) begin
                scan_addr_reg <= (scan_addr_reg == LAST_IDX) ? '0 : scan_addr_reg + 1'b1;
                cmp_vld_reg   <= 1'b1;
                if (rd_hit) begin
                    found_reg <= 1'b1;
                end
                if (rd_free) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.new_ent) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.pop_wr && (ent_len_reg == LEN_W'(1))) begin
                valid_reg[found_idx_reg] <= 1'b0;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Entry memory: one registered read port for the scan, one write port.
    assign ent_we    = cmd.new_ent || cmd.app_wr || cmd.pop_wr;
    assign ent_waddr = found_reg ? found_idx_reg : free_idx_reg;

    always_comb begin
        ent_wdata.key = req_key_reg;
        priority if (cmd.app_wr) begin
            ent_wdata.head = ent_head_reg;
            ent_wdata.tail = req_id_reg;
            ent_wdata.len  = ent_len_reg + 1'b1;
        end else if (cmd.pop_wr) begin
            ent_wdata.head = link_rd_reg;
            ent_wdata.tail = ent_tail_reg;
            ent_wdata.len  = ent_len_reg - 1'b1;
        end else begin
            ent_wdata.head = req_id_reg;
            ent_wdata.tail = req_id_reg;
            ent_wdata.len  = LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (cmd.scan) begin
            ent_rd_reg <= ent_mem[scan_addr_reg];
        end
    end

    // Link memory: the new id's link is cleared first, then the old tail is
    // pointed at it, so the tail write wins when both share an address.
    assign link_we    = cmd.new_ent || cmd.app_clr || cmd.app_wr;
    assign link_waddr = cmd.app_wr ? la_tab[ent_tail_reg] : la_tab[req_id_reg];
    assign link_wdata = cmd.app_wr ? req_id_reg : '0;

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.pop_rd) begin
            link_rd_reg <= link_mem[la_tab[ent_head_reg]];
        end
    end

    always_comb begin
        res_popped = '0;
        if (req_mode_reg == MODE_POP) begin
            if (found_reg) begin
                res_status = ST_POPPED;
                res_popped = ent_head_reg;
            end else begin
                res_status = ST_NOT_FOUND;
            end
        end else begin
            if (found_reg ? (ent_len_reg != LEN_MAX) : free_found_reg) begin
                res_status = ST_ADDED;
            end else begin
                res_status = ST_FULL;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_popped_id = m_popped_reg;

endmodule

`default_nettype wire

/* src/keyed_wait_queue_table.sv */
// Keyed wait queue table: one FIFO of waiting requester ids per key.
// Use: a request on the s_ channel (s_mode, s_key, s_waiter_id) either adds
// s_waiter_id to the tail of the queue tagged s_key or pops the head of
// that queue. Each request yields exactly one response on the m_ channel:
// m_status (added, popped, key not found, key table or queue full) and
// m_popped_id, which carries the removed id on a pop and zero otherwise.
// Both channels use valid/ready; a transfer happens when both are high.
// Flow: requests are handled one at a time; the key entries are scanned
// in order, one per cycle. The scan stops at the entry that holds the key
// or after the last of NUM_KEYS entries. An append then clears the new id's
// link and writes the entry, a pop reads the head's link and writes the
// entry, and a new queue writes a free entry. The next request is accepted
// the cycle after the response is registered, even while that response
// still waits.
// Stall: when m_ready is low the response holds in the output register; a
// following request is still taken and processed, and waits for the
// output register before its own response is loaded.
// Reset: aresetn is synchronous and active low. It clears all entry valid
// bits and the output valid flag, so every key starts empty. The entry and
// link memories are not cleared; unwritten contents are never used.
`default_nettype none

module keyed_wait_queue_table #(
    parameter int NUM_KEYS    = kwq_pkg::NUM_KEYS_DEF,
    parameter int NUM_WAITERS = kwq_pkg::NUM_WAITERS_DEF,
    parameter int KEY_BITS    = kwq_pkg::KEY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [kwq_pkg::KEY_IN_W-1:0]  s_key,
    input  wire logic [kwq_pkg::ID_W-1:0]      s_waiter_id,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kwq_pkg::ST_W-1:0]           m_status,
    output logic [kwq_pkg::ID_W-1:0]           m_popped_id
);
    import kwq_pkg::*;

    // Commands flow from the sequencer into the datapath; status flows back.
    kwq_cmd_t cmd;
    kwq_sts_t sts;

    kwq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kwq_datapath #(
        .NUM_KEYS    (NUM_KEYS),
        .NUM_WAITERS (NUM_WAITERS),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_mode      (s_mode),
        .s_key       (s_key),
        .s_waiter_id (s_waiter_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_popped_id (m_popped_id)
    );

endmodule

`default_nettype wire

/* src/kwq_checker.sv */
// Port-level checker of the keyed wait queue table, bound to the top level.
// Depends on kwq_pkg for the status codes and on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module kwq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [kwq_pkg::ST_W-1:0]      m_status,
    input wire logic [kwq_pkg::ID_W-1:0]      m_popped_id
);
    import kwq_pkg::*;

    // Requests accepted whose response has not yet been taken.
    logic [1:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc && (pend_reg != 2'd3)) begin
            pend_next = pend_reg + 1'b1;
        end else if (out_acc && !in_acc && (pend_reg != 2'd0)) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `ASSERT_CLKD(a_resp_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_popped_id), "stalled response changed")
    `ASSERT_CLKD(a_popped_zero, aclk, aresetn, m_valid && (m_status != ST_POPPED) |-> (m_popped_id == '0), "popped id set without a pop")
    `ASSERT_CLKD(a_no_spurious, aclk, aresetn, m_valid |-> (pend_reg != 2'd0), "response without a pending request")
    `ASSERT_CLKD(a_pend_bound, aclk, aresetn, pend_reg <= 2'd2, "more than two requests in flight")
    `ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> !m_valid, "response valid after reset")

endmodule

bind keyed_wait_queue_table kwq_checker u_kwq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_popped_id (m_popped_id)
);

`default_nettype wire
